@@ sv/parcor_all_pole_synthesis_filter_unit_assert.svh @@
// Assertion helpers for the PARCOR synthesis filter.
// Both expect clk and rst to be visible in the module that uses them.
`ifndef PARCOR_ALL_POLE_SYNTHESIS_FILTER_UNIT_ASSERT_SVH
`define PARCOR_ALL_POLE_SYNTHESIS_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication
`define PAF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define PAF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/paf_pkg.sv @@
// ----------------------------------------------------------------------------
// paf_pkg
// Shared types, register codes and helpers of the PARCOR synthesis filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package paf_pkg;

  localparam int MAX_POLES_DEF = 32;

  // Register indexes on the config channel
  localparam logic [1:0] REG_ORDER    = 2'd0;
  localparam logic [1:0] REG_DE_EN    = 2'd1;
  localparam logic [1:0] REG_DE_COEFF = 2'd2;

  // Reset values
  localparam logic [5:0]         ORDER_RST    = 6'd16;
  localparam logic signed [15:0] DE_COEFF_RST = 16'sd32113;  // 0.98 in Q1.15

  // Multiplier operand select
  typedef enum logic [1:0] {
    MS_SU   = 2'd0,
    MS_FIL  = 2'd1,
    MS_GAIN = 2'd2,
    MS_DE   = 2'd3
  } mul_sel_t;

  // What to do with the registered product
  typedef enum logic [1:0] {
    PT_NONE = 2'd0,
    PT_SU   = 2'd1,
    PT_ACC  = 2'd2,
    PT_GAIN = 2'd3
  } ptag_t;

  typedef struct packed {
    logic     load_item;
    logic     latch_set;
    logic     su_init;
    logic     mul_en;
    mul_sel_t mul_sel;
    ptag_t    tag;
    logic     acc_clr;
    logic     fl_done;
    logic     de_fin;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic latch_hit;
    logic de_en;
    logic out_free;
  } dp_stat_t;

  function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
    if (v > 40'sd32767) begin
      return 16'sh7fff;
    end else if (v < -40'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic logic ovf16(input logic signed [39:0] v);
    return (v > 40'sd32767) || (v < -40'sd32768);
  endfunction

endpackage

`default_nettype wire

@@ sv/paf_dp.sv @@
// ----------------------------------------------------------------------------
// paf_dp
// Datapath: registers, coefficient and history arrays, shared multiplier,
// accumulator, de-emphasis and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module paf_dp import paf_pkg::*; #(
  parameter int  MAX_POLES = MAX_POLES_DEF,
  localparam int IW = (MAX_POLES > 1) ? $clog2(MAX_POLES) : 1,
  localparam int CW = $clog2(MAX_POLES + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [15:0]          cfg_data,
  input  wire logic signed [15:0]   sample_in,
  input  wire logic signed [15:0]   refl_value,
  input  wire logic [5:0]           refl_index,
  input  wire logic signed [15:0]   gain_value,
  input  wire dp_cmd_t              cmd,
  input  wire logic [IW-1:0]        ridx,
  input  wire logic [IW-1:0]        widx,
  output dp_stat_t                  stat,
  output logic [CW-1:0]             eff_order,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output logic signed [15:0]        sample_out,
  output logic                      clipped
);

  localparam int AW = 49 + CW;
  localparam logic signed [AW-1:0] ACC_HALF = AW'(1) <<< 23;

  // Config registers
  logic [5:0]         filter_order;
  logic               deemph_enable;
  logic signed [15:0] deemph_coeff;

  // Arrays
  logic signed [15:0] staging [MAX_POLES];
  logic signed [15:0] active  [MAX_POLES];
  logic signed [31:0] direct  [MAX_POLES];
  logic signed [31:0] scratch [MAX_POLES];
  logic signed [15:0] hist    [MAX_POLES];
  logic signed [15:0] gain_act;
  logic signed [15:0] de_mem;

  // Item registers
  logic signed [15:0] x_reg;
  logic [5:0]         slot_reg;
  logic signed [15:0] g_reg;
  logic signed [15:0] k_reg;

  // Multiplier
  logic signed [31:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [47:0] prod;
  ptag_t              p_tag;
  logic [IW-1:0]      p_dst;

  logic signed [AW-1:0] acc;
  logic signed [15:0]   y_reg;
  logic                 clip_reg;

  logic [CW-1:0]        new_order;
  logic                 slot_ok_in;
  logic [5:0]           slot_m1;
  logic signed [32:0]   su_r;
  logic signed [33:0]   su_diff;
  logic signed [31:0]   su_sat;
  logic signed [AW-1:0] y_full;
  logic signed [15:0]   y_sat;
  logic                 y_ovf;
  logic signed [32:0]   de_r;
  logic signed [39:0]   de_sum;
  logic                 order_wr;

  function automatic logic [CW-1:0] eff_of(input logic [5:0] fo);
    logic [7:0] w;
    w = {2'b00, fo};
    if (fo == 6'd0) begin
      return CW'(1);
    end else if (w > 8'(MAX_POLES)) begin
      return CW'(MAX_POLES);
    end
    return CW'(w);
  endfunction

  assign eff_order = eff_of(filter_order);
  assign new_order = eff_of(cfg_data[5:0]);
  assign order_wr  = cfg_valid && (cfg_index == REG_ORDER);

  assign slot_ok_in = (refl_index != 6'd0) && ({2'b00, refl_index} <= 8'(MAX_POLES));
  assign slot_m1    = refl_index - 6'd1;

  assign stat.latch_hit = (slot_reg != 6'd0) && ({2'b00, slot_reg} <= 8'(MAX_POLES)) &&
                          ({2'b00, slot_reg} == 8'(eff_order));
  assign stat.de_en    = deemph_enable;
  assign stat.out_free = !out_valid || out_ready;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_order  <= ORDER_RST;
      deemph_enable <= 1'b0;
      deemph_coeff  <= DE_COEFF_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ORDER:    filter_order  <= cfg_data[5:0];
        REG_DE_EN:    deemph_enable <= cfg_data[0];
        REG_DE_COEFF: deemph_coeff  <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      x_reg    <= sample_in;
      slot_reg <= refl_index;
      g_reg    <= gain_value;
    end
    if (cmd.su_init) begin
      k_reg <= active[ridx];
    end
  end

  // Multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      MS_SU: begin
        mul_a = scratch[ridx];
        mul_b = k_reg;
      end
      MS_FIL: begin
        mul_a = direct[ridx];
        mul_b = hist[ridx];
      end
      MS_GAIN: begin
        mul_a = 32'(gain_act);
        mul_b = x_reg;
      end
      MS_DE: begin
        mul_a = 32'(deemph_coeff);
        mul_b = de_mem;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Registered product and its tag
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod  <= mul_a * mul_b;
      p_dst <= widx;
    end
    if (rst) begin
      p_tag <= PT_NONE;
    end else begin
      p_tag <= cmd.mul_en ? cmd.tag : PT_NONE;
    end
  end

  // Step-up write back: a_j = sat32(s_j - round(k * s_(i-j)))
  assign su_r    = 33'((prod + 48'sd16384) >>> 15);
  assign su_diff = 34'(scratch[p_dst]) - 34'(su_r);
  always_comb begin
    if (su_diff > 34'sh0_7fff_ffff) begin
      su_sat = 32'sh7fff_ffff;
    end else if (su_diff < -34'sh0_8000_0000) begin
      su_sat = 32'sh8000_0000;
    end else begin
      su_sat = su_diff[31:0];
    end
  end

  // Filter output rounding
  assign y_full = (acc + ACC_HALF) >>> 24;
  assign y_sat  = sat16(40'(y_full));
  assign y_ovf  = ovf16(40'(y_full));

  // De-emphasis sum
  assign de_r   = 33'((prod + 48'sd16384) >>> 15);
  assign de_sum = 40'(y_reg) + 40'(de_r);

  // Coefficient and history arrays
  always_ff @(posedge clk) begin
    for (int e = 0; e < MAX_POLES; e++) begin
      if (rst) begin
        staging[e] <= '0;
        active[e]  <= '0;
        direct[e]  <= '0;
        hist[e]    <= '0;
      end else if (order_wr && (CW'(e) >= eff_order) && (CW'(e) < new_order)) begin
        staging[e] <= '0;
        direct[e]  <= '0;
        hist[e]    <= '0;
      end else begin
        if (cmd.load_item && slot_ok_in && (IW'(slot_m1) == IW'(e))) begin
          staging[e] <= refl_value;
        end
        if (cmd.latch_set && (CW'(e) < eff_order)) begin
          active[e] <= staging[e];
        end
        if (cmd.su_init && (ridx == IW'(e))) begin
          direct[e] <= {{7{active[e][15]}}, active[e], 9'd0};
        end else if ((p_tag == PT_SU) && (p_dst == IW'(e))) begin
          direct[e] <= su_sat;
        end
        if (cmd.fl_done) begin
          if (e == 0) begin
            hist[e] <= y_sat;
          end else if (CW'(e) < eff_order) begin
            hist[e] <= hist[(e > 0) ? e - 1 : 0];
          end
        end
      end
    end
  end

  // Work copy for one recursion order
  always_ff @(posedge clk) begin
    if (cmd.su_init) begin
      for (int e = 0; e < MAX_POLES; e++) begin
        scratch[e] <= direct[e];
      end
    end
  end

  // Gain, accumulator, result and de-emphasis memory
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_act <= '0;
      de_mem   <= '0;
    end else begin
      if (cmd.latch_set) begin
        gain_act <= g_reg;
      end
      if (cmd.de_fin) begin
        de_mem <= sat16(de_sum);
      end
    end
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (p_tag == PT_ACC) begin
      acc <= acc + AW'(prod);
    end else if (p_tag == PT_GAIN) begin
      acc <= acc + (AW'(prod) <<< 12);
    end
    if (cmd.fl_done) begin
      y_reg    <= y_sat;
      clip_reg <= y_ovf;
    end else if (cmd.de_fin) begin
      y_reg    <= sat16(de_sum);
      clip_reg <= clip_reg | ovf16(de_sum);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      sample_out <= y_reg;
      clipped    <= clip_reg;
    end
  end

endmodule

`default_nettype wire

@@ sv/paf_ctrl.sv @@
// ----------------------------------------------------------------------------
// paf_ctrl
// Sequencer: coefficient latch, step-up recursion, filter MAC and output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module paf_ctrl import paf_pkg::*; #(
  parameter int  MAX_POLES = MAX_POLES_DEF,
  localparam int IW = (MAX_POLES > 1) ? $clog2(MAX_POLES) : 1,
  localparam int CW = $clog2(MAX_POLES + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire dp_stat_t      stat,
  input  wire logic [CW-1:0] eff_order,
  output dp_cmd_t            cmd,
  output logic [IW-1:0]      ridx,
  output logic [IW-1:0]      widx
);

`include "parcor_all_pole_synthesis_filter_unit_assert.svh"

  typedef enum logic [10:0] {
    ST_IDLE     = 11'b000_0000_0001,
    ST_DECIDE   = 11'b000_0000_0010,
    ST_SU_INIT  = 11'b000_0000_0100,
    ST_SU_MUL   = 11'b000_0000_1000,
    ST_SU_WAIT  = 11'b000_0001_0000,
    ST_FL_START = 11'b000_0010_0000,
    ST_FL_MUL   = 11'b000_0100_0000,
    ST_FL_WAIT  = 11'b000_1000_0000,
    ST_FL_DONE  = 11'b001_0000_0000,
    ST_DE_FIN   = 11'b010_0000_0000,
    ST_OUT      = 11'b100_0000_0000
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] i, i_next;
  logic [CW-1:0] j, j_next;
  logic [IW-1:0] n, n_next;

  assign in_ready = (state == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    i_next     = i;
    j_next     = j;
    n_next     = n;
    cmd        = '0;
    ridx       = '0;
    widx       = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (stat.latch_hit) begin
          cmd.latch_set = 1'b1;
          i_next        = CW'(1);
          state_next    = ST_SU_INIT;
        end else begin
          state_next = ST_FL_START;
        end
      end
      ST_SU_INIT: begin
        cmd.su_init = 1'b1;
        ridx        = IW'(i - CW'(1));
        j_next      = CW'(1);
        state_next  = (i == CW'(1)) ? ST_SU_WAIT : ST_SU_MUL;
      end
      ST_SU_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_SU;
        cmd.tag     = PT_SU;
        ridx        = IW'(i - j - CW'(1));
        widx        = IW'(j - CW'(1));
        j_next      = j + CW'(1);
        if (j == i - CW'(1)) begin
          state_next = ST_SU_WAIT;
        end
      end
      ST_SU_WAIT: begin
        if (i == eff_order) begin
          state_next = ST_FL_START;
        end else begin
          i_next     = i + CW'(1);
          state_next = ST_SU_INIT;
        end
      end
      ST_FL_START: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_GAIN;
        cmd.tag     = PT_GAIN;
        cmd.acc_clr = 1'b1;
        n_next      = '0;
        state_next  = ST_FL_MUL;
      end
      ST_FL_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_FIL;
        cmd.tag     = PT_ACC;
        ridx        = n;
        n_next      = n + IW'(1);
        if (CW'(n) + CW'(1) == eff_order) begin
          state_next = ST_FL_WAIT;
        end
      end
      ST_FL_WAIT: begin
        state_next = ST_FL_DONE;
      end
      ST_FL_DONE: begin
        cmd.fl_done = 1'b1;
        if (stat.de_en) begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MS_DE;
          cmd.tag     = PT_NONE;
          state_next  = ST_DE_FIN;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_DE_FIN: begin
        cmd.de_fin = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i     <= '0;
      j     <= '0;
      n     <= '0;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
      n     <= n_next;
    end
  end

  // Checks
  `PAF_ASSERT_NEXT(a_accept_decide, in_valid && in_ready, state == ST_DECIDE, "accept did not go to decide")
  `PAF_ASSERT_IMP(a_su_range, state == ST_SU_MUL, (j != '0) && (j < i) && (i <= eff_order), "step-up index out of range")
  `PAF_ASSERT_IMP(a_fl_range, state == ST_FL_MUL, CW'(n) < eff_order, "filter tap index out of range")
  `PAF_ASSERT_IMP(a_out_free, cmd.out_load, stat.out_free, "output loaded while occupied")

endmodule

`default_nettype wire

@@ sv/parcor_all_pole_synthesis_filter_unit.sv @@
// ----------------------------------------------------------------------------
// parcor_all_pole_synthesis_filter_unit
// All-pole synthesis filter fed by reflection coefficients.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one beat per excitation sample, with an optional
//   reflection coefficient, its 1-based slot and a gain. The beat whose slot
//   equals the active order latches the staged set and the gain and runs the
//   step-up recursion on one shared 32x16 multiplier.
//   m_axis returns one beat per input beat: the saturated sample and a clip
//   flag. The cfg channel (always ready) writes the order, de-emphasis enable
//   and de-emphasis coefficient; write it only while the block is idle.
//   Each beat makes the gain multiply and one multiply per filter tap,
//   plus one more with de-emphasis. A beat that latches coefficients
//   first runs the step-up recursion up to the effective order.
//   Reset clears the coefficients, history and gain and restores the default
//   registers. The result waits in an output register; a new beat is taken
//   while it waits, and a stalled receiver holds the next result in the
//   sequencer until the register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module parcor_all_pole_synthesis_filter_unit import paf_pkg::*; #(
  parameter int MAX_POLES = MAX_POLES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // sample_in[15:0], refl_value[31:16], refl_index[37:32], gain_value[53:38]
  input  wire logic [55:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // sample_out[15:0]
  output logic [15:0]      m_axis_tdata,
  // clipped[0]
  output logic [0:0]       m_axis_tuser,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int IW = (MAX_POLES > 1) ? $clog2(MAX_POLES) : 1;
  localparam int CW = $clog2(MAX_POLES + 1);

  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic [IW-1:0]      ridx;
  logic [IW-1:0]      widx;
  logic [CW-1:0]      eff_order;
  logic signed [15:0] sample_out;
  logic               clipped;

  assign cfg_ready = 1'b1;

  paf_ctrl #(
    .MAX_POLES (MAX_POLES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .stat      (stat),
    .eff_order (eff_order),
    .cmd       (cmd),
    .ridx      (ridx),
    .widx      (widx)
  );

  paf_dp #(
    .MAX_POLES (MAX_POLES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_in  (s_axis_tdata[15:0]),
    .refl_value (s_axis_tdata[31:16]),
    .refl_index (s_axis_tdata[37:32]),
    .gain_value (s_axis_tdata[53:38]),
    .cmd        (cmd),
    .ridx       (ridx),
    .widx       (widx),
    .stat       (stat),
    .eff_order  (eff_order),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .sample_out (sample_out),
    .clipped    (clipped)
  );

  assign m_axis_tdata    = sample_out;
  assign m_axis_tuser[0] = clipped;

endmodule

`default_nettype wire

@@ tb/parcor_all_pole_synthesis_filter_unit_chk.sv @@
// ----------------------------------------------------------------------------
// parcor_all_pole_synthesis_filter_unit_chk
// Watches all three channels of the PARCOR synthesis filter, keeps its own
// model of coefficients, history and de-emphasis, and compares each output
// beat with the oldest predicted sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module parcor_all_pole_synthesis_filter_unit_chk import paf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic [0:0]  m_axis_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  localparam int NP = MAX_POLES_DEF;

  typedef struct packed {
    logic [15:0] sample;
    logic        clip;
  } filt_out_t;

  // Model state
  logic [5:0]         order_reg;
  logic               de_en;
  logic signed [15:0] de_coeff;
  logic signed [15:0] staged [NP];
  logic signed [15:0] refl   [NP];
  logic signed [31:0] dcoef  [NP];
  logic signed [15:0] hist   [NP];
  logic signed [15:0] gain;
  logic signed [15:0] de_mem;
  filt_out_t          samples_due[$];

  assign pending = samples_due.size();

  function automatic int clamp_order(logic [5:0] v);
    if (v < 1) return 1;
    if (v > NP) return NP;
    return int'(v);
  endfunction

  // Round half up by sh bits (floor after adding half)
  function automatic longint rnd(longint v, int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Reflection to direct-form conversion
  task automatic run_step_up(int n);
    logic signed [31:0] prev [NP];
    longint k, p;
    for (int i = 1; i <= n; i++) begin
      k = refl[i-1];
      for (int j = 0; j < i - 1; j++) prev[j] = dcoef[j];
      dcoef[i-1] = 32'(k * 512);
      for (int j = 1; j < i; j++) begin
        p = rnd(k * longint'(prev[i-j-1]), 15);
        dcoef[j-1] = 32'(clamp32(longint'(prev[j-1]) - p));
      end
    end
  endtask

  task automatic filter_sample(logic [55:0] d);
    int                 n;
    logic signed [15:0] x, kv, g;
    logic [5:0]         slot;
    longint             acc, v;
    logic signed [15:0] y;
    logic               clip;
    filt_out_t          r;
    n    = clamp_order(order_reg);
    x    = d[15:0];
    kv   = d[31:16];
    slot = d[37:32];
    g    = d[53:38];
    clip = 1'b0;
    if (slot >= 1 && slot <= NP) begin
      staged[slot-1] = kv;
      if (int'(slot) == n) begin
        for (int i = 0; i < n; i++) refl[i] = staged[i];
        gain = g;
        run_step_up(n);
      end
    end
    acc = longint'(gain) * longint'(x) * 4096;
    for (int i = 0; i < n; i++) acc += longint'(dcoef[i]) * longint'(hist[i]);
    v = rnd(acc, 24);
    if (v > 32767) begin y = 16'sh7fff; clip = 1'b1; end
    else if (v < -32768) begin y = 16'sh8000; clip = 1'b1; end
    else y = 16'(v);
    for (int i = n - 1; i > 0; i--) hist[i] = hist[i-1];
    hist[0] = y;
    if (de_en) begin
      v = longint'(y) + rnd(longint'(de_coeff) * longint'(de_mem), 15);
      if (v > 32767) begin y = 16'sh7fff; clip = 1'b1; end
      else if (v < -32768) begin y = 16'sh8000; clip = 1'b1; end
      else y = 16'(v);
      de_mem = y;
    end
    r.sample = y;
    r.clip   = clip;
    samples_due.push_back(r);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    int was, now;
    case (idx)
      REG_ORDER: begin
        was       = clamp_order(order_reg);
        order_reg = val[5:0];
        now       = clamp_order(order_reg);
        for (int i = was; i < now; i++) begin
          staged[i] = '0;
          dcoef[i]  = '0;
          hist[i]   = '0;
        end
      end
      REG_DE_EN:    de_en = val[0];
      REG_DE_COEFF: de_coeff = val;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    filt_out_t e;
    if (rst) begin
      order_reg = ORDER_RST;
      de_en     = 1'b0;
      de_coeff  = DE_COEFF_RST;
      for (int i = 0; i < NP; i++) begin
        staged[i] = '0; refl[i] = '0; dcoef[i] = '0; hist[i] = '0;
      end
      gain   = '0;
      de_mem = '0;
      samples_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) write_reg(cfg_index, cfg_data);
      if (s_axis_tvalid && s_axis_tready) filter_sample(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (samples_due.size() == 0) begin
          $error("output beat with no sample expected: sample_out %h", m_axis_tdata);
          fail_count++;
        end else begin
          e = samples_due.pop_front();
          if (m_axis_tdata !== e.sample) begin
            $error("sample_out: expected %h, got %h", e.sample, m_axis_tdata);
            fail_count++;
          end
          if (m_axis_tuser[0] !== e.clip) begin
            $error("clipped: expected %b, got %b", e.clip, m_axis_tuser[0]);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

@@ tb/parcor_all_pole_synthesis_filter_unit_tb.sv @@
// ----------------------------------------------------------------------------
// parcor_all_pole_synthesis_filter_unit_tb
// Drives sample beats with coefficient sets across several order and
// de-emphasis settings, with random idling on both sides and one long
// receiver stall; the checker does all prediction and comparison.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module parcor_all_pole_synthesis_filter_unit_tb import paf_pkg::*;;

  localparam int WATCHDOG = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  int          fail_count;
  int          pending;

  bit          calm = 1'b0;     // no idling in the closing part
  bit          hold_rx = 1'b0;  // long receiver stall request
  int          idle_cycles = 0;
  int          cur_order = 16;

  always #5 clk = ~clk;

  parcor_all_pole_synthesis_filter_unit i_dut (.*);

  parcor_all_pole_synthesis_filter_unit_chk i_chk (.*);

  // Watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, or a long hold when requested
  initial begin
    int n;
    @(posedge clk iff !rst);
    forever begin
      if (hold_rx) begin
        m_axis_tready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_rx = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        n = $urandom_range(1, 7);
        repeat (n) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk iff cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_ORDER) begin
      cur_order = (val[5:0] == 0) ? 1 : (val[5:0] > 32 ? 32 : int'(val[5:0]));
    end
    @(posedge clk);
  endtask

  // Valid stays up after a beat; the next send or drain sets it
  task automatic send(logic [15:0] x, logic [15:0] k, logic [5:0] slot, logic [15:0] g);
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      n = $urandom_range(1, 7);
      repeat (n) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, g, slot, k, x};
    @(posedge clk iff s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (40) @(posedge clk);
  endtask

  // Small reflection values keep the filter mostly stable
  function automatic logic [15:0] pick_refl();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return 16'($signed($urandom_range(0, 24000)) - 12000);
    endcase
  endfunction

  // One coefficient set for the current order, then plain samples
  task automatic send_frame(int samples);
    for (int s = 1; s <= cur_order; s++) begin
      send(16'($urandom), pick_refl(), 6'(s), 16'($urandom_range(0, 16'hffff)));
    end
    for (int s = 0; s < samples; s++) begin
      case ($urandom_range(0, 9))
        0: send(16'($urandom), 16'($urandom), 6'($urandom_range(0, 63)), 16'($urandom));
        default: send(16'($urandom), 16'($urandom), 6'd0, 16'($urandom));
      endcase
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes at reset order, gain only then coefficients
    send(16'h7fff, 16'h0000, 6'd0,  16'h7fff);
    send(16'h8000, 16'h7fff, 6'd1,  16'h8000);
    send(16'h8000, 16'h8000, 6'd16, 16'h7fff);
    send(16'h7fff, 16'h1234, 6'd0,  16'h0000);
    send(16'h8000, 16'hffff, 6'd33, 16'hffff);   // slot beyond range
    send(16'h0001, 16'h4000, 6'd63, 16'h1000);
    send(16'hffff, 16'h0000, 6'd0,  16'h1000);
    drain();
    cfg_write(REG_ORDER, 16'd0);                 // zero acts as one
    cfg_write(REG_DE_EN, 16'd1);
    cfg_write(REG_DE_COEFF, 16'h7fff);
    send(16'h7fff, 16'h7fff, 6'd1, 16'h7fff);
    send(16'h7fff, 16'h0000, 6'd0, 16'h0000);
    send(16'h8000, 16'h8000, 6'd1, 16'h8000);
    send(16'h0000, 16'h0000, 6'd0, 16'h0000);
    drain();
    cfg_write(REG_DE_COEFF, 16'h8000);
    cfg_write(REG_ORDER, 16'd63);                // clamps to 32, clears new slots
    send(16'h4000, 16'h2000, 6'd32, 16'h1000);
    send(16'h7fff, 16'h0000, 6'd0,  16'h1000);
    send(16'h8000, 16'h0000, 6'd0,  16'h1000);
    drain();
    cfg_write(REG_DE_EN, 16'd0);
    cfg_write(REG_ORDER, 16'd3);
    send(16'h2000, 16'h7fff, 6'd3, 16'h1000);

    // Long stall with the sender still offering beats
    hold_rx = 1'b1;
    send_frame(20);
    drain();

    // Random phases across settings
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) calm = 1'b1;
      cfg_write(REG_ORDER, 16'($urandom_range(0, 63) < 8 ?
                $urandom_range(0, 63) : $urandom_range(1, 8)));
      cfg_write(REG_DE_EN, 16'($urandom_range(0, 1)));
      cfg_write(REG_DE_COEFF, 16'($urandom));
      for (int f = 0; f < 4; f++) send_frame($urandom_range(10, 20));
      drain();
    end
    drain();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
